/* rtl/psme_pkg.sv */
// psme_pkg: widths, state types, the divider request struct and helpers
// for the p-square median estimator; no dependencies
package psme_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int FRAC_BITS   = 16;
    localparam int COUNT_BITS  = 32;

    localparam int NMARK   = 5;
    localparam int H_W     = SAMPLE_BITS + FRAC_BITS;
    localparam int N_W     = COUNT_BITS;
    localparam int DP_W    = COUNT_BITS + 2;
    localparam int D_W     = DP_W + 2;
    localparam int M_W     = COUNT_BITS + 2;
    localparam int X_W     = 64;
    localparam int P_W     = M_W + X_W;
    localparam int STEP_W  = $clog2(P_W);
    localparam int SSTEP_W = $clog2(NMARK);

    localparam logic signed [X_W-1:0] S64_MAX = {1'b0, {(X_W-1){1'b1}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WLOAD,
        ST_WSORT,
        ST_UPD,
        ST_TEST,
        ST_T1,
        ST_T2,
        ST_QH,
        ST_LIN,
        ST_DONE
    } psme_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    typedef struct packed {
        logic        [M_W-1:0] mul;
        logic signed [X_W-1:0] val;
        logic        [M_W-1:0] dvs;
    } md_req_t;

    function automatic logic signed [X_W-1:0] sext_h(input logic signed [H_W-1:0] h);
        return {{(X_W-H_W){h[H_W-1]}}, h};
    endfunction

    // symmetric saturating add to +-(2^63-1)
    function automatic logic signed [X_W-1:0] sat_add(input logic signed [X_W-1:0] x,
                                                      input logic signed [X_W-1:0] y);
        logic signed [X_W:0] s;
        logic signed [X_W:0] lim;
        s   = {x[X_W-1], x} + {y[X_W-1], y};
        lim = {1'b0, S64_MAX};
        if (s > lim)
        begin
            return S64_MAX;
        end
        else if (s < -lim)
        begin
            return -S64_MAX;
        end
        return s[X_W-1:0];
    endfunction

endpackage

/* rtl/psme_muldiv.sv */
// psme_muldiv: shared serial unit for (m * x) / d, truncating, saturated
// depends on psme_pkg
module psme_muldiv (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  psme_pkg::md_req_t              req,
    output logic                           done,
    output logic signed [psme_pkg::X_W-1:0] res
);

    psme_pkg::md_state_t st_reg, st_next;
    logic [psme_pkg::P_W-1:0]    p_reg, p_next;
    logic [psme_pkg::X_W-1:0]    mag_reg, mag_next;
    logic [psme_pkg::M_W-1:0]    dvs_reg, dvs_next;
    logic [psme_pkg::M_W-1:0]    rem_reg, rem_next;
    logic                        neg_reg, neg_next;
    logic [psme_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        done_reg, done_next;
    logic signed [psme_pkg::X_W-1:0] res_reg, res_next;

    logic [psme_pkg::X_W:0]   sum;
    logic [psme_pkg::M_W:0]   rem_sh;
    logic [psme_pkg::M_W:0]   diff;
    logic                     ge;
    logic                     ovf;
    logic [psme_pkg::X_W-2:0] q63;
    logic signed [psme_pkg::X_W-1:0] mg;

    always_comb
    begin
        st_next   = st_reg;
        p_next    = p_reg;
        mag_next  = mag_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        sum    = {1'b0, p_reg[psme_pkg::P_W-1:psme_pkg::M_W]}
               + (p_reg[0] ? {1'b0, mag_reg} : '0);
        rem_sh = {rem_reg, p_reg[psme_pkg::P_W-1]};
        diff   = rem_sh - {1'b0, dvs_reg};
        ge     = (rem_sh >= {1'b0, dvs_reg});
        ovf    = 1'b0;
        q63    = '0;
        mg     = '0;
        case (st_reg)
            psme_pkg::MD_IDLE:
            begin
                if (start)
                begin
                    neg_next  = req.val[psme_pkg::X_W-1];
                    mag_next  = req.val[psme_pkg::X_W-1] ? -req.val : req.val;
                    p_next    = {{psme_pkg::X_W{1'b0}}, req.mul};
                    dvs_next  = req.dvs;
                    step_next = psme_pkg::STEP_W'(psme_pkg::M_W - 1);
                    st_next   = psme_pkg::MD_MUL;
                end
            end
            psme_pkg::MD_MUL:
            begin
                p_next = {sum, p_reg[psme_pkg::M_W-1:1]};
                if (step_reg == '0)
                begin
                    rem_next  = '0;
                    step_next = psme_pkg::STEP_W'(psme_pkg::P_W - 1);
                    st_next   = psme_pkg::MD_DIV;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            psme_pkg::MD_DIV:
            begin
                rem_next = ge ? diff[psme_pkg::M_W-1:0] : rem_sh[psme_pkg::M_W-1:0];
                p_next   = {p_reg[psme_pkg::P_W-2:0], ge};
                if (step_reg == '0)
                begin
                    ovf = |p_next[psme_pkg::P_W-1:psme_pkg::X_W-1];
                    q63 = ovf ? psme_pkg::S64_MAX[psme_pkg::X_W-2:0]
                              : p_next[psme_pkg::X_W-2:0];
                    mg  = {1'b0, q63};
                    res_next  = (dvs_reg == '0) ? '0 : (neg_reg ? -mg : mg);
                    done_next = 1'b1;
                    st_next   = psme_pkg::MD_IDLE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            default:
            begin
                st_next = psme_pkg::MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= psme_pkg::MD_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        mag_reg  <= mag_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        step_reg <= step_next;
        res_reg  <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> st_reg == psme_pkg::MD_IDLE)
        else $error("divider started while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held");
    a_res_sym: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> res_reg != {1'b1, {(psme_pkg::X_W-1){1'b0}}})
        else $error("divider result outside symmetric range");

endmodule

/* rtl/p_square_median_estimator.sv */
// p_square_median_estimator: streaming p-square median estimate, top level
// depends on psme_pkg and psme_muldiv
//
// one sample transfer in gives one result transfer out (median, ready_res,
// saturated). both channels are valid/ready.
// the first four samples give the median of the padded warm-up buffer;
// the fifth sorts the buffer into the five markers and sets ready_res.
// the result becomes valid in the same cycle as sample_ready returns.
// a warm-up item passes through accept, buffer load, five odd-even sort
// passes and result load.
// a later item runs, for each middle marker that moves, three or four
// passes of the serial multiply-divide unit (start, 34 multiply steps,
// 98 divide steps, hand-off).
// once the sample count is at its maximum an item leaves the state alone
// and returns saturated = 1.
// a new sample is taken while the previous result still waits; the block
// then holds its finished result until result_ready frees the output
// register. reset clears markers, positions, count and rdy_reg.
module p_square_median_estimator (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    sample_valid,
    output logic                                    sample_ready,
    input  logic signed [psme_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                    result_valid,
    input  logic                                    result_ready,
    output logic signed [psme_pkg::H_W-1:0]         median,
    output logic                                    ready_res,
    output logic                                    saturated
);

    psme_pkg::psme_state_t state_reg, state_next;

    logic signed [psme_pkg::SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic                                    ign_reg, ign_next;
    logic signed [psme_pkg::H_W-1:0]  q_reg  [psme_pkg::NMARK];
    logic signed [psme_pkg::H_W-1:0]  q_next [psme_pkg::NMARK];
    logic [psme_pkg::N_W-1:0]         n_reg  [psme_pkg::NMARK];
    logic [psme_pkg::N_W-1:0]         n_next [psme_pkg::NMARK];
    logic [psme_pkg::DP_W-1:0]        dp_reg [psme_pkg::NMARK];
    logic [psme_pkg::DP_W-1:0]        dp_next[psme_pkg::NMARK];
    logic signed [psme_pkg::SAMPLE_BITS-1:0] wb_reg [psme_pkg::NMARK];
    logic signed [psme_pkg::SAMPLE_BITS-1:0] wb_next[psme_pkg::NMARK];
    logic signed [psme_pkg::SAMPLE_BITS-1:0] srt_reg [psme_pkg::NMARK];
    logic signed [psme_pkg::SAMPLE_BITS-1:0] srt_next[psme_pkg::NMARK];
    logic [psme_pkg::N_W-1:0]         cnt_reg, cnt_next;
    logic                             rdy_reg, rdy_next;
    logic [psme_pkg::SSTEP_W-1:0]     sstep_reg, sstep_next;
    logic [1:0]                       idx_reg, idx_next;
    logic                             neg_reg, neg_next;
    logic signed [psme_pkg::X_W-1:0]  t1_reg, t1_next;
    logic                             md_go_reg, md_go_next;
    psme_pkg::md_req_t                md_req_reg, md_req_next;
    logic                             ov_reg, ov_next;
    logic signed [psme_pkg::H_W-1:0]  med_reg, med_next;
    logic                             rr_reg, rr_next;
    logic                             so_reg, so_next;

    logic                             md_done;
    logic signed [psme_pkg::X_W-1:0]  md_res;

    logic signed [psme_pkg::H_W-1:0]  qm, qc, qp, h;
    logic [psme_pkg::N_W-1:0]         nm, nc, np;
    logic [psme_pkg::DP_W-1:0]        dpc;
    logic [psme_pkg::M_W-1:0]         a, b;
    logic signed [psme_pkg::D_W-1:0]  d;
    logic signed [psme_pkg::X_W-1:0]  sm, num, qh;
    logic [2:0]                       c;
    logic [1:0]                       k;
    logic                             mv, adv;
    logic signed [psme_pkg::SAMPLE_BITS-1:0] tmp;

    psme_muldiv u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_go_reg),
        .req   (md_req_reg),
        .done  (md_done),
        .res   (md_res)
    );

    // neighbours of the marker under adjustment
    always_comb
    begin
        case (idx_reg)
            2'd2:
            begin
                qm = q_reg[1]; qc = q_reg[2]; qp = q_reg[3];
                nm = n_reg[1]; nc = n_reg[2]; np = n_reg[3]; dpc = dp_reg[2];
            end
            2'd3:
            begin
                qm = q_reg[2]; qc = q_reg[3]; qp = q_reg[4];
                nm = n_reg[2]; nc = n_reg[3]; np = n_reg[4]; dpc = dp_reg[3];
            end
            default:
            begin
                qm = q_reg[0]; qc = q_reg[1]; qp = q_reg[2];
                nm = n_reg[0]; nc = n_reg[1]; np = n_reg[2]; dpc = dp_reg[1];
            end
        endcase
    end

    assign a = {2'b00, nc} - {2'b00, nm};
    assign b = {2'b00, np} - {2'b00, nc};
    assign d = $signed({2'b00, dpc}) - $signed({2'b00, nc, 2'b00});
    assign h = {smp_reg, {psme_pkg::FRAC_BITS{1'b0}}};

    always_comb
    begin
        state_next  = state_reg;
        smp_next    = smp_reg;
        ign_next    = ign_reg;
        q_next      = q_reg;
        n_next      = n_reg;
        dp_next     = dp_reg;
        wb_next     = wb_reg;
        srt_next    = srt_reg;
        cnt_next    = cnt_reg;
        rdy_next    = rdy_reg;
        sstep_next  = sstep_reg;
        idx_next    = idx_reg;
        neg_next    = neg_reg;
        t1_next     = t1_reg;
        md_go_next  = 1'b0;
        md_req_next = md_req_reg;
        ov_next     = ov_reg & ~result_ready;
        med_next    = med_reg;
        rr_next     = rr_reg;
        so_next     = so_reg;
        c   = cnt_reg[2:0];
        k   = 2'd0;
        mv  = 1'b0;
        adv = 1'b0;
        sm  = '0;
        num = '0;
        qh  = '0;
        tmp = '0;
        case (state_reg)
            psme_pkg::ST_IDLE:
            begin
                if (sample_valid)
                begin
                    smp_next = sample;
                    ign_next = 1'b0;
                    if (!rdy_reg)
                    begin
                        state_next = psme_pkg::ST_WLOAD;
                    end
                    else if (cnt_reg == '1)
                    begin
                        ign_next   = 1'b1;
                        state_next = psme_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = psme_pkg::ST_UPD;
                    end
                end
            end
            psme_pkg::ST_WLOAD:
            begin
                for (int i = 0; i < psme_pkg::NMARK; i++)
                begin
                    if (c == 3'(i))
                    begin
                        wb_next[i] = smp_reg;
                    end
                    srt_next[i] = (3'(i) < c) ? wb_reg[i] : smp_reg;
                end
                cnt_next   = cnt_reg + 1'b1;
                sstep_next = '0;
                state_next = psme_pkg::ST_WSORT;
            end
            psme_pkg::ST_WSORT:
            begin
                // odd-even transposition pass
                for (int i = 0; i < psme_pkg::NMARK - 1; i++)
                begin
                    if ((i % 2) == int'(sstep_reg[0]) && srt_reg[i+1] < srt_reg[i])
                    begin
                        tmp           = srt_reg[i];
                        srt_next[i]   = srt_reg[i+1];
                        srt_next[i+1] = tmp;
                    end
                end
                sstep_next = sstep_reg + 1'b1;
                if (sstep_reg == psme_pkg::SSTEP_W'(psme_pkg::NMARK - 1))
                begin
                    if (cnt_reg == psme_pkg::N_W'(psme_pkg::NMARK))
                    begin
                        for (int i = 0; i < psme_pkg::NMARK; i++)
                        begin
                            q_next[i]  = {srt_next[i], {psme_pkg::FRAC_BITS{1'b0}}};
                            n_next[i]  = psme_pkg::N_W'(i + 1);
                            dp_next[i] = psme_pkg::DP_W'(4 * (i + 1));
                        end
                        rdy_next = 1'b1;
                    end
                    state_next = psme_pkg::ST_DONE;
                end
            end
            psme_pkg::ST_UPD:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (h < q_reg[0])
                begin
                    q_next[0] = h;
                    k = 2'd0;
                end
                else if (h < q_reg[1])
                begin
                    k = 2'd0;
                end
                else if (h < q_reg[2])
                begin
                    k = 2'd1;
                end
                else if (h < q_reg[3])
                begin
                    k = 2'd2;
                end
                else
                begin
                    if (h > q_reg[4])
                    begin
                        q_next[4] = h;
                    end
                    k = 2'd3;
                end
                for (int i = 0; i < psme_pkg::NMARK; i++)
                begin
                    if (3'(i) > {1'b0, k})
                    begin
                        n_next[i] = n_reg[i] + 1'b1;
                    end
                    dp_next[i] = dp_reg[i] + psme_pkg::DP_W'(i);
                end
                idx_next   = 2'd1;
                state_next = psme_pkg::ST_TEST;
            end
            psme_pkg::ST_TEST:
            begin
                mv = (d >= 4 && b > 1) || (d <= -4 && a > 1);
                if (mv)
                begin
                    neg_next        = d[psme_pkg::D_W-1];
                    md_req_next.mul = d[psme_pkg::D_W-1] ? a - 1'b1 : a + 1'b1;
                    md_req_next.val = psme_pkg::sext_h(qp) - psme_pkg::sext_h(qc);
                    md_req_next.dvs = b;
                    md_go_next      = 1'b1;
                    state_next      = psme_pkg::ST_T1;
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            psme_pkg::ST_T1:
            begin
                if (md_done)
                begin
                    t1_next         = md_res;
                    md_req_next.mul = neg_reg ? b + 1'b1 : b - 1'b1;
                    md_req_next.val = psme_pkg::sext_h(qc) - psme_pkg::sext_h(qm);
                    md_req_next.dvs = a;
                    md_go_next      = 1'b1;
                    state_next      = psme_pkg::ST_T2;
                end
            end
            psme_pkg::ST_T2:
            begin
                if (md_done)
                begin
                    sm              = psme_pkg::sat_add(t1_reg, md_res);
                    num             = neg_reg ? -sm : sm;
                    md_req_next.mul = psme_pkg::M_W'(1);
                    md_req_next.val = num;
                    md_req_next.dvs = a + b;
                    md_go_next      = 1'b1;
                    state_next      = psme_pkg::ST_QH;
                end
            end
            psme_pkg::ST_QH:
            begin
                if (md_done)
                begin
                    qh = psme_pkg::sat_add(psme_pkg::sext_h(qc), md_res);
                    if (qh > psme_pkg::sext_h(qm) && qh < psme_pkg::sext_h(qp))
                    begin
                        for (int i = 1; i < psme_pkg::NMARK - 1; i++)
                        begin
                            if (idx_reg == 2'(i))
                            begin
                                q_next[i] = qh[psme_pkg::H_W-1:0];
                                n_next[i] = neg_reg ? nc - 1'b1 : nc + 1'b1;
                            end
                        end
                        adv = 1'b1;
                    end
                    else
                    begin
                        // linear fallback towards the neighbour on the move side
                        md_req_next.mul = psme_pkg::M_W'(1);
                        md_req_next.val = neg_reg
                            ? psme_pkg::sext_h(qm) - psme_pkg::sext_h(qc)
                            : psme_pkg::sext_h(qp) - psme_pkg::sext_h(qc);
                        md_req_next.dvs = neg_reg ? a : b;
                        md_go_next      = 1'b1;
                        state_next      = psme_pkg::ST_LIN;
                    end
                end
            end
            psme_pkg::ST_LIN:
            begin
                if (md_done)
                begin
                    for (int i = 1; i < psme_pkg::NMARK - 1; i++)
                    begin
                        if (idx_reg == 2'(i))
                        begin
                            q_next[i] = qc + md_res[psme_pkg::H_W-1:0];
                            n_next[i] = neg_reg ? nc - 1'b1 : nc + 1'b1;
                        end
                    end
                    adv = 1'b1;
                end
            end
            psme_pkg::ST_DONE:
            begin
                if (!ov_reg || result_ready)
                begin
                    ov_next    = 1'b1;
                    med_next   = rdy_reg ? q_reg[2]
                                         : {srt_reg[2], {psme_pkg::FRAC_BITS{1'b0}}};
                    rr_next    = rdy_reg;
                    so_next    = ign_reg;
                    state_next = psme_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psme_pkg::ST_IDLE;
            end
        endcase
        if (adv)
        begin
            if (idx_reg == 2'd3)
            begin
                state_next = psme_pkg::ST_DONE;
            end
            else
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = psme_pkg::ST_TEST;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psme_pkg::ST_IDLE;
            for (int i = 0; i < psme_pkg::NMARK; i++)
            begin
                q_reg[i]  <= '0;
                n_reg[i]  <= '0;
                dp_reg[i] <= '0;
            end
            cnt_reg   <= '0;
            rdy_reg   <= 1'b0;
            sstep_reg <= '0;
            idx_reg   <= 2'd1;
            md_go_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            q_reg     <= q_next;
            n_reg     <= n_next;
            dp_reg    <= dp_next;
            cnt_reg   <= cnt_next;
            rdy_reg   <= rdy_next;
            sstep_reg <= sstep_next;
            idx_reg   <= idx_next;
            md_go_reg <= md_go_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg    <= smp_next;
        ign_reg    <= ign_next;
        wb_reg     <= wb_next;
        srt_reg    <= srt_next;
        neg_reg    <= neg_next;
        t1_reg     <= t1_next;
        md_req_reg <= md_req_next;
        med_reg    <= med_next;
        rr_reg     <= rr_next;
        so_reg     <= so_next;
    end

    assign sample_ready = (state_reg == psme_pkg::ST_IDLE);
    assign result_valid = ov_reg;
    assign median       = med_reg;
    assign ready_res    = rr_reg;
    assign saturated    = so_reg;

    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> (state_reg == psme_pkg::ST_T1 || state_reg == psme_pkg::ST_T2 ||
                     state_reg == psme_pkg::ST_QH || state_reg == psme_pkg::ST_LIN))
        else $error("divider result outside a wait state");
    a_rdy_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rdy_reg |=> rdy_reg)
        else $error("markers lost ready");
    a_pos_order: assert property (@(posedge clk) disable iff (!rst_n)
        (rdy_reg && state_reg == psme_pkg::ST_IDLE) |->
            (n_reg[0] < n_reg[1] && n_reg[1] < n_reg[2] &&
             n_reg[2] < n_reg[3] && n_reg[3] < n_reg[4]))
        else $error("marker positions out of order");

endmodule

/* test/tb_p_square_median_estimator.sv */
// tb_p_square_median_estimator: self-checking testbench for the streaming p-square median block
// scoreboard class predicts every result from accepted samples; needs psme_pkg and the rtl only
`timescale 1ns / 100ps

module tb_p_square_median_estimator;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int HOLD_CYCLES    = 500;
    localparam int N_RANDOM       = 1780;

    typedef struct {
        logic [psme_pkg::H_W-1:0] median;
        logic                     ready_res;
        logic                     saturated;
    } estimate_t;

    class median_scoreboard;
        longint        warm[5];
        longint        q[5];
        longint        n[5];
        longint        dp[5];
        longint        count;
        bit            primed;
        estimate_t     pending[$];
        int            mismatches;
        int            checked;

        function void clear();
            for (int i = 0; i < 5; i++)
            begin
                warm[i] = 0;
                q[i]    = 0;
                n[i]    = 0;
                dp[i]   = 0;
            end
            count      = 0;
            primed     = 0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void sort5(ref longint v[5]);
            longint t;
            for (int i = 0; i < 5; i++)
            begin
                for (int j = i + 1; j < 5; j++)
                begin
                    if (v[j] < v[i])
                    begin
                        t    = v[i];
                        v[i] = v[j];
                        v[j] = t;
                    end
                end
            end
        endfunction

        function longint sat_sum(longint x, longint y);
            logic signed [64:0] s;
            s = $signed({x[63], x}) + $signed({y[63], y});
            if (s > $signed({1'b0, psme_pkg::S64_MAX}))
                return psme_pkg::S64_MAX;
            if (s < -$signed({1'b0, psme_pkg::S64_MAX}))
                return -psme_pkg::S64_MAX;
            return s[63:0];
        endfunction

        // exact (m * x) / dv, truncating, saturated
        function longint scaled_quotient(longint unsigned m, longint x, longint unsigned dv);
            logic [63:0]  mag;
            logic [127:0] prod;
            logic [127:0] quo;
            longint       r;
            if (dv == 0)
                return 0;
            mag  = x[63] ? -x : x;
            prod = {64'd0, mag} * {64'd0, m};
            quo  = prod / {64'd0, dv};
            if (quo > {64'd0, psme_pkg::S64_MAX})
                r = psme_pkg::S64_MAX;
            else
                r = quo[63:0];
            return x[63] ? -r : r;
        endfunction

        function void nudge_marker(int i);
            longint d, s, a, b, t1, t2, num, qhat, gap;
            int     j;
            d = dp[i] - 4 * n[i];
            if (!((d >= 4 && n[i+1] - n[i] > 1) || (d <= -4 && n[i-1] - n[i] < -1)))
                return;
            s   = d >= 0 ? 1 : -1;
            a   = n[i] - n[i-1];
            b   = n[i+1] - n[i];
            t1  = scaled_quotient(a + s, q[i+1] - q[i], b);
            t2  = scaled_quotient(b - s, q[i] - q[i-1], a);
            num = sat_sum(t1, t2);
            if (s < 0)
                num = -num;
            qhat = sat_sum(q[i], (a + b) > 0 ? num / (a + b) : 0);
            if (qhat > q[i-1] && qhat < q[i+1])
                q[i] = qhat;
            else
            begin
                j   = s > 0 ? i + 1 : i - 1;
                gap = s > 0 ? n[j] - n[i] : n[i] - n[j];
                if (gap > 0)
                    q[i] += (q[j] - q[i]) / gap;
            end
            n[i] += s;
        endfunction

        function void note_sample(logic signed [psme_pkg::SAMPLE_BITS-1:0] v);
            longint    h;
            longint    c[5];
            int        k;
            estimate_t e;
            h = longint'(v) <<< psme_pkg::FRAC_BITS;
            e.saturated = 0;
            if (!primed)
            begin
                if (count < 5)
                    warm[count] = h;
                count++;
                if (count >= 5)
                begin
                    count = 5;
                    sort5(warm);
                    for (int i = 0; i < 5; i++)
                    begin
                        q[i]  = warm[i];
                        n[i]  = i + 1;
                        dp[i] = 4 * (i + 1);
                    end
                    primed = 1;
                end
            end
            else if (count >= (64'd1 << psme_pkg::COUNT_BITS) - 1)
                e.saturated = 1;
            else
            begin
                count++;
                if (h < q[0])
                begin
                    q[0] = h;
                    k    = 0;
                end
                else if (h < q[1])
                    k = 0;
                else if (h < q[2])
                    k = 1;
                else if (h < q[3])
                    k = 2;
                else
                begin
                    if (h > q[4])
                        q[4] = h;
                    k = 3;
                end
                for (int i = k + 1; i < 5; i++)
                    n[i]++;
                for (int i = 0; i < 5; i++)
                    dp[i] += i;
                for (int i = 1; i <= 3; i++)
                    nudge_marker(i);
            end
            if (primed)
                e.median = q[2][psme_pkg::H_W-1:0];
            else
            begin
                for (int i = 0; i < 5; i++)
                    c[i] = i < count ? warm[i] : warm[count-1];
                sort5(c);
                e.median = c[2][psme_pkg::H_W-1:0];
            end
            e.ready_res = primed;
            pending.push_back(e);
        endfunction

        function void check_result(logic [psme_pkg::H_W-1:0] m, logic r, logic s);
            estimate_t e;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: median %h", m);
                return;
            end
            e = pending.pop_front();
            if (e.median !== m || e.ready_res !== r || e.saturated !== s)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected median %h rdy %b sat %b, got %h %b %b",
                             checked, e.median, e.ready_res, e.saturated, m, r, s);
            end
        endfunction
    endclass

    logic                                    clk;
    logic                                    rst_n;
    logic                                    sample_valid;
    logic                                    sample_ready;
    logic signed [psme_pkg::SAMPLE_BITS-1:0] sample;
    logic                                    result_valid;
    logic                                    result_ready;
    logic signed [psme_pkg::H_W-1:0]         median;
    logic                                    ready_res;
    logic                                    saturated;

    median_scoreboard book;
    bit               quiet;
    bit               hold_req;
    int               idle_cycles;

    p_square_median_estimator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .median       (median),
        .ready_res    (ready_res),
        .saturated    (saturated)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    task automatic send_sample(logic signed [psme_pkg::SAMPLE_BITS-1:0] v);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            sample_valid = 0;
            repeat (gap) @(negedge clk);
        end
        sample_valid = 1;
        sample       = v;
        do
            @(posedge clk);
        while (!sample_ready);
        book.note_sample(v);
        @(negedge clk);
    endtask

    function automatic logic signed [psme_pkg::SAMPLE_BITS-1:0] draw_sample();
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 20)
            return $urandom;
        if (mode < 55)
            return $signed($urandom_range(0, 2000)) - 1000;
        if (mode < 75)
            return $signed($urandom_range(0, 40)) - 20;
        return $signed($urandom_range(0, 32'h200000)) - 32'sh100000;
    endfunction

    // receiver
    initial
    begin
        int wait_n;
        result_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_ready = 0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 0;
            end
            wait_n = quiet ? 0 : $urandom_range(0, 12);
            if (wait_n > 0)
            begin
                result_ready = 0;
                repeat (wait_n) @(negedge clk);
            end
            result_ready = 1;
            do
                @(posedge clk);
            while (!result_valid);
            book.check_result(median, ready_res, saturated);
        end
    end

    // watchdog
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((sample_valid && sample_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_p_square_median_estimator: errors");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [psme_pkg::SAMPLE_BITS-1:0] warm_vals[5];
        logic signed [psme_pkg::SAMPLE_BITS-1:0] directed[20];
        book         = new();
        book.clear();
        quiet        = 0;
        hold_req     = 0;
        rst_n        = 0;
        sample_valid = 0;
        sample       = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        warm_vals = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1};
        foreach (warm_vals[i])
            send_sample(warm_vals[i]);
        directed = '{32'sh7fffffff, 32'sh80000000, 0, 0, 0, -1, 1, 32'sh7fffffff,
                     32'sh80000000, 5, -5, 0, 32'sh40000000, -32'sh40000000, 2, -2,
                     32'sh7ffffffe, 32'sh80000001, 0, 3};
        quiet = 1;
        foreach (directed[i])
            send_sample(directed[i]);
        quiet = 0;

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 400 == 100)
                quiet = 1;
            if (i % 400 == 160)
                quiet = 0;
            if (i == 700)
                hold_req = 1;
            send_sample(draw_sample());
        end
        sample_valid = 0;

        while (book.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("%0d results checked: warm-up extremes, directed marker edges, random streams",
                 book.checked);
        $display("held output for %0d cycles once; count saturation is out of reach in a run",
                 HOLD_CYCLES);
        if (book.mismatches == 0)
            $display("tb_p_square_median_estimator: clean");
        else
        begin
            $display("%0d mismatches", book.mismatches);
            $display("tb_p_square_median_estimator: errors");
        end
        $finish;
    end

endmodule
